>>> rtl/core/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Types and constants shared by the timing wheel controller and its cells.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int ID_W    = 6;
  localparam int ROT_W   = 16;
  localparam int SLOT_IN_W = 6;
  localparam int DELAY_W = 6;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 6'd3;

  // command codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_REFRESH = 2'd2,
    MODE_TICK    = 2'd3
  } htw_mode_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CMD    = 2'd1,
    ST_SCAN   = 2'd2,
    ST_FINISH = 2'd3
  } htw_state_e;

  // input word
  typedef struct packed {
    htw_mode_e             mode;
    logic [ID_W-1:0]       timer_id;
    logic [SLOT_IN_W-1:0]  slot;
    logic [ROT_W-1:0]      rotation;
  } htw_in_t;

  // output word
  typedef struct packed {
    logic [ID_W-1:0] timer_id_res;
    logic            expired;
    logic            status;
    logic            last;
  } htw_out_t;

  // broadcast control from the controller to every cell
  typedef struct packed {
    logic             wr_add;
    logic             wr_remove;
    logic             wr_refresh;
    logic             step;
    logic [ID_W-1:0]  timer_id;
    logic [ROT_W-1:0] rotation;
  } htw_cell_ctl_t;

endpackage

>>> rtl/core/htw_cell.sv
// ----------------------------------------------------------------------------
// htw_cell
// One timer entry of the wheel: active flag, slot and rotation count, plus
// the scan token that walks from cell to cell during a tick.
// ----------------------------------------------------------------------------
module htw_cell #(
  parameter int IDX    = 0,
  parameter int SLOT_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  htw_pkg::htw_cell_ctl_t ctl_i,
  input  logic [SLOT_W-1:0]     add_slot_i,
  input  logic [SLOT_W-1:0]     refresh_slot_i,
  input  logic [SLOT_W-1:0]     cur_slot_i,
  input  logic                  tok_i,
  output logic                  tok_o,
  output logic                  sel_active_o,
  output logic                  expire_o
);
  import htw_pkg::*;

  logic               active_q, active_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [ROT_W-1:0]   rot_q, rot_d;
  logic               tok_q, tok_d;
  logic               sel;
  logic               hit;

  // addressed by the current command
  assign sel = (ctl_i.timer_id == ID_W'(IDX));

  // token holder with a timer in the current slot
  assign hit = tok_q && active_q && (slot_q == cur_slot_i);

  assign expire_o     = hit && (rot_q == '0);
  assign sel_active_o = sel && active_q;
  assign tok_o        = tok_q;

  // entry update
  always_comb begin
    active_d = active_q;
    slot_d   = slot_q;
    rot_d    = rot_q;
    tok_d    = tok_q;
    if (ctl_i.step) begin
      tok_d = tok_i;
      if (hit) begin
        if (rot_q != '0) begin
          rot_d = rot_q - ROT_W'(1);
        end else begin
          active_d = 1'b0;
        end
      end
    end
    if (sel && ctl_i.wr_add) begin
      active_d = 1'b1;
      slot_d   = add_slot_i;
      rot_d    = ctl_i.rotation;
    end
    if (sel && ctl_i.wr_remove) begin
      active_d = 1'b0;
    end
    if (sel && ctl_i.wr_refresh) begin
      slot_d = refresh_slot_i;
      rot_d  = '0;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  // timer payload, meaningful only while active
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    rot_q  <= rot_d;
  end

endmodule

>>> rtl/core/hashed_timing_wheel.sv
// ----------------------------------------------------------------------------
// hashed_timing_wheel
// Timing wheel over a row of timer cells with add, remove, refresh and tick.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid_i / in_ready_o, results leave on
// out_valid_o / out_ready_i; both use a valid/ready handshake. The refresh
// delay register is written with cfg_we_i / cfg_wdata_i between words by
// the user; the block itself does not enforce this. Add, remove and refresh
// give one word each: the accepted word is held in cmd_q and its result
// enters the output register once the output is free. A tick walks a token
// through the timer cells one cell per cycle while the receiver keeps up;
// each expired timer gives one word in ascending index order, the highest
// one flagged last, or a single word with last set when nothing expires.
// A new word is accepted only once the previous one has been fully handled;
// the output register holds a finished word while the next is taken in.
// When the receiver stalls with an earlier expiry held back, the scan halts
// at the next expiring cell until the word ahead of it leaves; otherwise it
// keeps walking.
// Reset clears all active flags, sets the wheel pointer to slot 0 and the
// refresh delay to 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hashed_timing_wheel #(
  parameter int SLOTS      = 64,
  parameter int MAX_TIMERS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  htw_pkg::htw_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output htw_pkg::htw_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [htw_pkg::DELAY_W-1:0]       cfg_wdata_i
);
  import htw_pkg::*;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TBL_N    = 2 ** SLOT_IN_W;

  // small constant table: value modulo SLOTS for every 6-bit value
  function automatic logic [SLOT_W-1:0] mod_entry(int v);
    return SLOT_W'(v % SLOTS);
  endfunction

  logic [SLOT_W-1:0] slot_tbl [TBL_N];
  for (genvar v = 0; v < TBL_N; v++) begin : g_tbl
    assign slot_tbl[v] = mod_entry(v);
  end

  htw_state_e           state_q, state_d;
  htw_in_t              cmd_q;
  logic                 pend_q, pend_d;
  logic [ID_W-1:0]      pend_id_q, pend_id_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [DELAY_W-1:0]   delay_q;
  logic                 out_valid_q, out_valid_d;
  htw_out_t             out_q, out_d;

  htw_cell_ctl_t        ctl;
  logic                 start;
  logic                 push;
  logic                 out_free;
  logic                 present;
  logic                 addr_active;
  logic                 any_expire;
  logic [ID_W-1:0]      exp_id;
  logic [SLOT_W-1:0]    add_slot;
  logic [SLOT_W-1:0]    refresh_slot;
  logic [SLOT_W-1:0]    dmod;
  logic [SLOT_W:0]      ref_sum;
  logic [SLOT_W-1:0]    cur_next;

  logic [MAX_TIMERS-1:0] tok_vec;
  logic [MAX_TIMERS-1:0] sel_act_vec;
  logic [MAX_TIMERS-1:0] expire_vec;

  // cell row, token passed from each cell to the next
  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = start;
    end else begin : g_link
      assign tok_in = tok_vec[i-1];
    end
    htw_cell #(
      .IDX    (i),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl),
      .add_slot_i     (add_slot),
      .refresh_slot_i (refresh_slot),
      .cur_slot_i     (cur_q),
      .tok_i          (tok_in),
      .tok_o          (tok_vec[i]),
      .sel_active_o   (sel_act_vec[i]),
      .expire_o       (expire_vec[i])
    );
  end

  // expiring cell index, at most one cell holds the token
  always_comb begin
    exp_id = '0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (expire_vec[i]) begin
        exp_id = exp_id | ID_W'(i);
      end
    end
  end

  assign any_expire  = |expire_vec;
  assign addr_active = |sel_act_vec;
  assign present     = ({1'b0, cmd_q.timer_id} < (ID_W+1)'(MAX_TIMERS));
  assign out_free    = !out_valid_q || out_ready_i;

  // slot arithmetic
  assign add_slot     = slot_tbl[cmd_q.slot];
  assign dmod         = slot_tbl[delay_q];
  assign ref_sum      = {1'b0, cur_q} + {1'b0, dmod};
  assign refresh_slot = (ref_sum >= (SLOT_W+1)'(SLOTS)) ?
                        SLOT_W'(ref_sum - (SLOT_W+1)'(SLOTS)) : SLOT_W'(ref_sum);
  assign cur_next     = (cur_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_q + SLOT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CMD;
      end
      ST_CMD: begin
        if (cmd_q.mode == MODE_TICK) begin
          state_d = ST_SCAN;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!(any_expire && pend_q && !out_free) && tok_vec[MAX_TIMERS-1]) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    ctl          = '0;
    ctl.timer_id = cmd_q.timer_id;
    ctl.rotation = cmd_q.rotation;
    start        = 1'b0;
    push         = 1'b0;
    out_d        = out_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    cur_d        = cur_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_CMD: begin
        if (cmd_q.mode == MODE_TICK) begin
          // load the token into the first cell
          ctl.step = 1'b1;
          start    = 1'b1;
        end else if (out_free) begin
          push               = 1'b1;
          out_d.timer_id_res = cmd_q.timer_id;
          out_d.expired      = 1'b0;
          out_d.last         = 1'b1;
          unique case (cmd_q.mode)
            MODE_ADD: begin
              ctl.wr_add   = present;
              out_d.status = !present;
            end
            MODE_REMOVE: begin
              ctl.wr_remove = present && addr_active;
              out_d.status  = !(present && addr_active);
            end
            default: begin
              ctl.wr_refresh = present && addr_active;
              out_d.status   = !(present && addr_active);
            end
          endcase
        end
      end
      ST_SCAN: begin
        // hold one expiry back so the last one can be flagged
        if (!(any_expire && pend_q && !out_free)) begin
          ctl.step = 1'b1;
          if (any_expire) begin
            if (pend_q) begin
              push  = 1'b1;
              out_d = htw_out_t'{timer_id_res: pend_id_q, expired: 1'b1,
                                 status: 1'b0, last: 1'b0};
            end
            pend_d    = 1'b1;
            pend_id_d = exp_id;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_q) begin
            out_d = htw_out_t'{timer_id_res: pend_id_q, expired: 1'b1,
                               status: 1'b0, last: 1'b1};
          end else begin
            out_d = htw_out_t'{timer_id_res: '0, expired: 1'b0,
                               status: 1'b0, last: 1'b1};
          end
          pend_d = 1'b0;
          cur_d  = cur_next;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      cur_q       <= '0;
      delay_q     <= DELAY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) delay_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cmd_q <= in_data_i;
    pend_id_q <= pend_id_d;
    if (push) out_q <= out_d;
  end

  // at most one cell holds the scan token
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token");

  // the token is somewhere in the row for the whole scan
  a_tok_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (tok_vec != '0))
    else $error("scan without token");

  // no expiry is left pending between words
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q)
    else $error("pending expiry while idle");

  // wheel pointer stays within the slot range
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_q} < (SLOT_W+1)'(SLOTS)))
    else $error("wheel pointer out of range");

  // a timer command produces a final word
  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMD && cmd_q.mode != MODE_TICK && out_free)
    |=> (out_valid_o && out_data_o.last && !out_data_o.expired))
    else $error("command word missing");

endmodule
